FILE: hdl/rlpse_pkg.sv
// Shared types and constants for the streaming RLP encoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package rlpse_pkg;

  localparam int LenW  = 32;
  localparam int ByteW = 8;
  localparam int MaxOut = 5;
  localparam int CntW  = $clog2(MaxOut + 1);

  // func codes
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_DATA  = 2'd1;
  localparam logic [1:0] FUNC_LIST  = 2'd2;

  localparam logic [ByteW-1:0] STR_SHORT  = 8'h80;
  localparam logic [ByteW-1:0] STR_LONG   = 8'hB7;
  localparam logic [ByteW-1:0] LIST_SHORT = 8'hC0;
  localparam logic [ByteW-1:0] LIST_LONG  = 8'hF7;
  localparam logic [ByteW-1:0] SINGLE_HDR = 8'h81;
  localparam logic [LenW-1:0]  SHORT_LIM  = 32'd56;

  // All result words caused by one input word.
  typedef struct packed {
    logic [CntW-1:0]               cnt;
    logic [MaxOut-1:0][ByteW-1:0]  bytes;
    logic                          misuse;
  } grp_t;

endpackage

`default_nettype wire

FILE: hdl/rlpse_core.sv
// Encoder core: open-string tracking state and the one-pass encode of a word.
// Depends on rlpse_pkg.
`default_nettype none

module rlpse_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       take,
  input  wire logic [1:0]                 func,
  input  wire logic [rlpse_pkg::LenW-1:0]  length,
  input  wire logic [rlpse_pkg::ByteW-1:0] data_byte,
  output rlpse_pkg::grp_t                 grp
);
  import rlpse_pkg::*;

  logic [LenW-1:0] bytes_remaining, bytes_remaining_next;
  logic            single_pending, single_pending_next;
  logic            open_str;
  grp_t            hdr;
  logic [2:0]      nb;
  logic [ByteW-1:0] short_base, long_base;

  assign open_str   = (bytes_remaining != '0) || single_pending;
  assign short_base = (func == FUNC_LIST) ? LIST_SHORT : STR_SHORT;
  assign long_base  = (func == FUNC_LIST) ? LIST_LONG  : STR_LONG;

  always_comb begin
    if (length[31:24] != '0) begin
      nb = 3'd4;
    end else if (length[23:16] != '0) begin
      nb = 3'd3;
    end else if (length[15:8] != '0) begin
      nb = 3'd2;
    end else begin
      nb = 3'd1;
    end
  end

  // Length prefix: short form or long form with big-endian length bytes.
  always_comb begin
    hdr = '0;
    if (length < SHORT_LIM) begin
      hdr.cnt      = CntW'(1);
      hdr.bytes[0] = short_base + length[7:0];
    end else begin
      hdr.cnt      = CntW'(nb) + CntW'(1);
      hdr.bytes[0] = long_base + ByteW'(nb);
      case (nb)
        3'd4:    hdr.bytes[4:1] = {length[7:0], length[15:8], length[23:16], length[31:24]};
        3'd3:    hdr.bytes[3:1] = {length[7:0], length[15:8], length[23:16]};
        3'd2:    hdr.bytes[2:1] = {length[7:0], length[15:8]};
        default: hdr.bytes[1]   = length[7:0];
      endcase
    end
  end

  always_comb begin
    grp                  = '0;
    bytes_remaining_next = bytes_remaining;
    single_pending_next  = single_pending;
    unique case (func)
      FUNC_START: begin
        if (open_str) begin
          grp.cnt    = CntW'(1);
          grp.misuse = 1'b1;
        end else if (length == LenW'(1)) begin
          single_pending_next  = 1'b1;
          bytes_remaining_next = LenW'(1);
        end else begin
          bytes_remaining_next = length;
          grp = hdr;
        end
      end
      FUNC_DATA: begin
        if (!open_str) begin
          grp.cnt    = CntW'(1);
          grp.misuse = 1'b1;
        end else if (single_pending) begin
          single_pending_next  = 1'b0;
          bytes_remaining_next = '0;
          if (data_byte[7]) begin
            grp.cnt      = CntW'(2);
            grp.bytes[0] = SINGLE_HDR;
            grp.bytes[1] = data_byte;
          end else begin
            grp.cnt      = CntW'(1);
            grp.bytes[0] = data_byte;
          end
        end else begin
          bytes_remaining_next = bytes_remaining - LenW'(1);
          grp.cnt      = CntW'(1);
          grp.bytes[0] = data_byte;
        end
      end
      FUNC_LIST: begin
        if (open_str) begin
          grp.cnt    = CntW'(1);
          grp.misuse = 1'b1;
        end else begin
          grp = hdr;
        end
      end
      default: ;  // unused code: no words, state held
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= '0;
      single_pending  <= 1'b0;
    end else if (take) begin
      bytes_remaining <= bytes_remaining_next;
      single_pending  <= single_pending_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rlpse_out.sv
// Result register and serializer: holds one encoded group, sends a byte a word.
// Depends on rlpse_pkg.
`default_nettype none

module rlpse_out (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        take,
  input  wire rlpse_pkg::grp_t             grp_in,
  output logic                             load_ok,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [rlpse_pkg::ByteW-1:0]      out_byte,
  output logic                             last,
  output logic                             misuse
);
  import rlpse_pkg::*;

  grp_t            grp;
  logic [CntW-1:0] idx;
  logic            pop;

  assign last     = (idx == grp.cnt - CntW'(1));
  assign out_byte = grp.bytes[idx];
  assign misuse   = grp.misuse;
  assign pop      = out_valid && out_ready && last;
  // next group may load as the last byte of this one leaves
  assign load_ok  = !out_valid || pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (take) begin
      out_valid <= (grp_in.cnt != '0);
      idx       <= '0;
    end else if (pop) begin
      out_valid <= 1'b0;
    end else if (out_valid && out_ready) begin
      idx <= idx + CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      grp <= grp_in;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rlp_stream_encoder.sv
// Top level of the streaming RLP encoder.
// Depends on rlpse_pkg, rlpse_core and rlpse_out.
`default_nettype none

// Streaming RLP encoder. Each input word is a string start, a string data
// byte or a list header; each output word is one encoded byte, with last
// marking the final byte caused by an input word and misuse flagging a data
// byte with no open string, or a start or list header while a string is
// unfinished. An input word is encoded in the cycle it is accepted and lands
// in a result register that sends its bytes one per cycle while out_ready is
// high. A data byte emits one byte; a header emits up to five bytes for a
// 32-bit length, all through the single output byte lane. A one-byte string
// start emits nothing until its byte arrives. Input is accepted while the
// last byte of the previous group is being taken, so streams keep full rate.
module rlp_stream_encoder (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  func,
  input  wire logic [rlpse_pkg::LenW-1:0]   length,
  input  wire logic [rlpse_pkg::ByteW-1:0]  data_byte,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [rlpse_pkg::ByteW-1:0]      out_byte,
  output logic                             last,
  output logic                             misuse
);
  import rlpse_pkg::*;

  grp_t grp;
  logic take;

  assign take = in_valid && in_ready;

  rlpse_core u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .func      (func),
    .length    (length),
    .data_byte (data_byte),
    .grp       (grp)
  );

  rlpse_out u_out (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .grp_in    (grp),
    .load_ok   (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last      (last),
    .misuse    (misuse)
  );

endmodule

`default_nettype wire

FILE: hdl/rlpse_checker.sv
// Port-level checks for rlp_stream_encoder, attached by bind.
// Depends on rlpse_pkg.
`default_nettype none

module rlpse_props (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [rlpse_pkg::ByteW-1:0] out_byte,
  input wire logic                        last,
  input wire logic                        misuse
);
  import rlpse_pkg::*;

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last)
      && $stable(misuse))
    else $error("output word changed while stalled");

  // a misuse word is a lone zero byte
  a_misuse_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && misuse |-> out_byte == '0 && last)
    else $error("malformed misuse word");

  // bytes of one group follow without a gap
  a_group_cont: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid)
    else $error("group broken before last byte");

  // nothing pending right after reset
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");

  // mid-group the input side stays closed
  a_in_blocked: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("input taken during a multi-byte group");

endmodule

bind rlp_stream_encoder rlpse_props u_rlpse_props (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_byte  (out_byte),
  .last      (last),
  .misuse    (misuse)
);

`default_nettype wire

FILE: tb/sv/rlpse_checker.sv
// Scoreboard for the streaming RLP encoder: watches both channels, predicts
// the encoded words and compares them as they leave the block.
// Depends on rlpse_pkg.
`timescale 1ns / 100ps

module rlpse_checker (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic                  in_ready,
  input  wire logic [1:0]            func,
  input  wire logic [rlpse_pkg::LenW-1:0]  length,
  input  wire logic [rlpse_pkg::ByteW-1:0] data_byte,
  input  wire logic                  out_valid,
  input  wire logic                  out_ready,
  input  wire logic [rlpse_pkg::ByteW-1:0] out_byte,
  input  wire logic                  last,
  input  wire logic                  misuse,
  output int                         fail_count,
  output int                         owed
);
  import rlpse_pkg::*;

  typedef struct packed {
    logic [ByteW-1:0] octet;
    logic             fin;
    logic             bad;
  } enc_t;

  enc_t            enc_q[$];
  logic [LenW-1:0] str_left;
  logic            one_wait;
  int              fails;

  initial begin
    fails = 0;
    str_left = '0;
    one_wait = 1'b0;
  end

  task automatic put(input logic [ByteW-1:0] o, input logic f, input logic m);
    enc_q.push_back(enc_t'{octet: o, fin: f, bad: m});
  endtask

  // Short form is one prefix byte; long form is base+count, then the
  // length big-endian without leading zero bytes.
  task automatic put_header(input logic [LenW-1:0] len, input logic [ByteW-1:0] short_base,
                            input logic [ByteW-1:0] long_base);
    int              n;
    logic [LenW-1:0] t;
    if (len < SHORT_LIM) begin
      put(short_base + len[ByteW-1:0], 1'b1, 1'b0);
    end else begin
      n = 0;
      t = len;
      while (t != 0) begin
        n++;
        t = t >> 8;
      end
      put(long_base + ByteW'(n), 1'b0, 1'b0);
      for (int i = n; i > 0; i--) put(len[8*(i-1) +: 8], i == 1, 1'b0);
    end
  endtask

  task automatic encode_word(input logic [1:0] f, input logic [LenW-1:0] len,
                             input logic [ByteW-1:0] b);
    logic str_open;
    str_open = (str_left != 0) || one_wait;
    case (f)
      FUNC_START: begin
        if (str_open) begin
          put(8'h00, 1'b1, 1'b1);
        end else if (len == 1) begin
          // prefix held back until the byte shows up
          one_wait = 1'b1;
          str_left = 1;
        end else begin
          str_left = len;
          put_header(len, STR_SHORT, STR_LONG);
        end
      end
      FUNC_DATA: begin
        if (!str_open) begin
          put(8'h00, 1'b1, 1'b1);
        end else if (one_wait) begin
          one_wait = 1'b0;
          str_left = '0;
          // a byte below 0x80 encodes itself
          if (b >= STR_SHORT) put(SINGLE_HDR, 1'b0, 1'b0);
          put(b, 1'b1, 1'b0);
        end else begin
          str_left = str_left - 1;
          put(b, 1'b1, 1'b0);
        end
      end
      FUNC_LIST: begin
        if (str_open) put(8'h00, 1'b1, 1'b1);
        else put_header(len, LIST_SHORT, LIST_LONG);
      end
      default: ;
    endcase
  endtask

  task automatic log_bad(input string what, input enc_t want, input enc_t got);
    fails++;
    if (fails <= 10)
      $display("%0t: %s: expected byte %02h last %0b misuse %0b, %s %02h last %0b misuse %0b",
               $time, what, want.octet, want.fin, want.bad, "got byte",
               got.octet, got.fin, got.bad);
  endtask

  always @(posedge clk) begin
    enc_t want;
    enc_t got;
    if (rst) begin
      enc_q.delete();
      str_left = '0;
      one_wait = 1'b0;
    end else begin
      got = enc_t'{octet: out_byte, fin: last, bad: misuse};
      // outgoing word first: a word accepted on this edge cannot leave yet
      if (out_valid && out_ready) begin
        if (enc_q.size() == 0) begin
          log_bad("unexpected word", enc_t'('0), got);
        end else begin
          want = enc_q.pop_front();
          if (want !== got) log_bad("mismatch", want, got);
        end
      end
      if (in_valid && in_ready) encode_word(func, length, data_byte);
    end
    owed <= enc_q.size();
    fail_count <= fails;
  end

endmodule

FILE: tb/sv/rlp_stream_encoder_tb.sv
// Testbench top for the streaming RLP encoder: clock, reset, directed and
// random input words, random output stalls, and the verdict.
// Depends on rlpse_pkg, rlp_stream_encoder and rlpse_checker.
`timescale 1ns / 100ps

module rlp_stream_encoder_tb;
  import rlpse_pkg::*;

  localparam logic [1:0] FUNC_NONE = 2'd3;   // unused selector, ignored by the block
  localparam int CycleLimit = 400_000;
  localparam int RandWords  = 85;
  localparam int CalmFrom   = 55;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       func = FUNC_START;
  logic [LenW-1:0]  length = '0;
  logic [ByteW-1:0] data_byte = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [ByteW-1:0] out_byte;
  logic             last;
  logic             misuse;
  int               fail_count;
  int               owed;

  int cycles = 0;
  int words_sent = 0;
  bit calm = 1'b0;

  logic [LenW-1:0] list_marks [7] = '{32'd0, 32'd55, 32'd56, 32'd256, 32'h0001_0000,
                                      32'h0100_0000, 32'hFFFF_FFFF};

  rlp_stream_encoder dut (.*);
  rlpse_checker chk (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // output side back-pressure
  always begin
    @(posedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    out_ready <= 1'b1;
  end

  task automatic send(input logic [1:0] f, input logic [LenW-1:0] len,
                      input logic [ByteW-1:0] b);
    in_valid  <= 1'b1;
    func      <= f;
    length    <= len;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    if (f != FUNC_NONE) words_sent++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // misuse or ignored words, depending on whether a string is open
  task automatic send_noise(input bit str_open);
    case ($urandom_range(0, 2))
      0: send(FUNC_NONE, $urandom, 8'($urandom));
      1: send(str_open ? FUNC_START : FUNC_DATA, $urandom, 8'($urandom));
      default: send(str_open ? FUNC_LIST : FUNC_DATA, $urandom, 8'($urandom));
    endcase
  endtask

  task automatic send_string(input logic [LenW-1:0] n);
    send(FUNC_START, n, 8'($urandom));
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) send_noise(1'b1);
      send(FUNC_DATA, $urandom, 8'($urandom));
    end
  endtask

  function automatic logic [LenW-1:0] str_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(0, 4);
    if (r < 80) return $urandom_range(5, 20);
    return $urandom_range(50, 60);
  endfunction

  function automatic logic [LenW-1:0] list_len();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 60);
      1: return $urandom;
      2: return $urandom >> $urandom_range(0, 31);
      default: return (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
    endcase
  endfunction

  initial begin
    int r;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(FUNC_NONE, '1, '1);
    send(FUNC_DATA, '0, 8'h5A);
    send(FUNC_START, 32'd0, 8'h00);
    send(FUNC_START, 32'd1, 8'h00);
    send(FUNC_DATA, 32'd0, 8'h00);
    send(FUNC_START, 32'd1, 8'h00);
    send(FUNC_DATA, 32'd0, 8'h7F);
    send(FUNC_START, 32'd1, 8'h00);
    send(FUNC_DATA, 32'd0, 8'h80);
    // single-byte string interrupted by a start, a list header and an ignored word, then completed
    send(FUNC_START, 32'd1, 8'h00);
    send(FUNC_START, 32'd3, 8'h00);
    send(FUNC_LIST, 32'd0, 8'h00);
    send(FUNC_NONE, 32'd0, 8'h00);
    send(FUNC_DATA, 32'd0, 8'hFF);
    send(FUNC_START, 32'd2, 8'h00);
    send(FUNC_DATA, 32'd0, 8'hFF);
    send(FUNC_DATA, 32'd0, 8'h00);
    send(FUNC_DATA, 32'd0, 8'h01);
    foreach (list_marks[i]) send(FUNC_LIST, list_marks[i], 8'h00);

    // two-byte length string
    send_string(32'd256 + $urandom_range(0, 3));

    words_sent = 0;
    while (words_sent < RandWords) begin
      if (words_sent >= CalmFrom) calm = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 65) send_string(str_len());
      else if (r < 88) send(FUNC_LIST, list_len(), 8'($urandom));
      else send_noise(1'b0);
    end

    // four-byte length string left open at the end
    calm = 1'b1;
    send(FUNC_START, 32'h0100_0000 | $urandom, 8'h00);
    repeat (3) send(FUNC_DATA, $urandom, 8'($urandom));
    send(FUNC_LIST, $urandom, 8'h00);
    send(FUNC_START, $urandom, 8'h00);

    in_valid <= 1'b0;
    do @(posedge clk); while (owed != 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
